/* src/dqvcl_pkg.sv */
// Shared widths, constants and beat types of the dq voltage circle limiter.
package dqvcl_pkg;

  localparam int unsigned VoltW   = 16;
  localparam int unsigned FracW   = 16;
  localparam int unsigned MagW    = 2 * VoltW;
  localparam int unsigned RadW    = VoltW + FracW;
  localparam int unsigned RemW    = 2 * RadW;
  localparam int unsigned AccW    = MagW + FracW;
  localparam int unsigned CandW   = RemW + 2;
  localparam int unsigned NumRoot = FracW;

  localparam logic [FracW-1:0] InvSqrt3    = 16'd37838;
  localparam logic [FracW-1:0] ModLimitRst = 16'd62259;

  typedef struct packed {
    logic signed [VoltW-1:0] d_voltage;
    logic signed [VoltW-1:0] q_voltage;
    logic        [VoltW-1:0] bus_voltage;
  } dqvcl_in_t;

  typedef struct packed {
    logic signed [VoltW-1:0] d_limited;
    logic signed [VoltW-1:0] q_limited;
    logic                    over_limit;
  } dqvcl_out_t;

  typedef struct packed {
    logic signed [VoltW-1:0] d_volt;
    logic signed [VoltW-1:0] q_volt;
    logic        [VoltW-1:0] d_mag;
    logic        [VoltW-1:0] q_mag;
    logic        [MagW-1:0]  mag2;
    logic        [RemW-1:0]  rem;
    logic        [AccW-1:0]  tacc;
    logic        [FracW-1:0] scale;
    logic                    over;
  } dqvcl_root_t;

endpackage

/* src/dqvcl_front.sv */
// Front stages: magnitudes, squared vector length, radius and over-limit test.
module dqvcl_front (
  input  logic                  clk_i,
  input  logic [4:0]            en_i,
  input  dqvcl_pkg::dqvcl_in_t  in_i,
  input  logic [15:0]           mod_limit_i,
  output dqvcl_pkg::dqvcl_root_t out_o
);
  import dqvcl_pkg::*;

  dqvcl_in_t               in0_q;
  logic signed [VoltW-1:0] d1_q, q1_q, d2_q, q2_q, d3_q, q3_q;
  logic        [VoltW-1:0] dm1_q, qm1_q, dm2_q, qm2_q, dm3_q, qm3_q;
  logic        [RadW-1:0]  t1_q, rq2_q;
  logic        [MagW-1:0]  dsq2_q, qsq2_q, mag3_q;
  logic        [RemW-1:0]  r2_3_q;
  logic        [VoltW-1:0] dm_d, qm_d;
  logic        [RadW+FracW-1:0] tm_d;
  dqvcl_root_t             out_q;

  assign dm_d = in0_q.d_voltage[VoltW-1] ? VoltW'(-in0_q.d_voltage) : VoltW'(in0_q.d_voltage);
  assign qm_d = in0_q.q_voltage[VoltW-1] ? VoltW'(-in0_q.q_voltage) : VoltW'(in0_q.q_voltage);
  assign tm_d = (RadW+FracW)'(t1_q) * (RadW+FracW)'(mod_limit_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      in0_q <= in_i;
    end
    if (en_i[1]) begin
      d1_q  <= in0_q.d_voltage;
      q1_q  <= in0_q.q_voltage;
      dm1_q <= dm_d;
      qm1_q <= qm_d;
      t1_q  <= RadW'(in0_q.bus_voltage) * RadW'(InvSqrt3);
    end
    if (en_i[2]) begin
      d2_q   <= d1_q;
      q2_q   <= q1_q;
      dm2_q  <= dm1_q;
      qm2_q  <= qm1_q;
      dsq2_q <= MagW'(dm1_q) * MagW'(dm1_q);
      qsq2_q <= MagW'(qm1_q) * MagW'(qm1_q);
      rq2_q  <= tm_d[RadW+FracW-1:FracW];
    end
    if (en_i[3]) begin
      d3_q   <= d2_q;
      q3_q   <= q2_q;
      dm3_q  <= dm2_q;
      qm3_q  <= qm2_q;
      mag3_q <= dsq2_q + qsq2_q;
      r2_3_q <= RemW'(rq2_q) * RemW'(rq2_q);
    end
    if (en_i[4]) begin
      out_q.d_volt <= d3_q;
      out_q.q_volt <= q3_q;
      out_q.d_mag  <= dm3_q;
      out_q.q_mag  <= qm3_q;
      out_q.mag2   <= mag3_q;
      out_q.rem    <= r2_3_q;
      out_q.tacc   <= '0;
      out_q.scale  <= '0;
      out_q.over   <= {mag3_q, {(RemW-MagW){1'b0}}} > r2_3_q;
    end
  end

  assign out_o = out_q;

endmodule

/* src/dqvcl_root_step.sv */
// One restoring step of the scale search, deciding a single bit of the scale.
module dqvcl_root_step #(
  parameter int unsigned BitPos = 15
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  dqvcl_pkg::dqvcl_root_t in_i,
  output dqvcl_pkg::dqvcl_root_t out_o
);
  import dqvcl_pkg::*;

  logic [CandW-1:0] cand_d;
  logic             take_d;
  dqvcl_root_t      out_d;
  dqvcl_root_t      out_q;

  assign cand_d = (CandW'(in_i.tacc) << (BitPos + 1)) + (CandW'(in_i.mag2) << (2 * BitPos));
  assign take_d = CandW'(in_i.rem) >= cand_d;

  always_comb begin
    out_d = in_i;
    if (take_d) begin
      out_d.rem           = RemW'(CandW'(in_i.rem) - cand_d);
      out_d.tacc          = in_i.tacc + (AccW'(in_i.mag2) << BitPos);
      out_d.scale[BitPos] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

/* src/dqvcl_back.sv */
// Back stages: scaling of both components and the output register.
module dqvcl_back (
  input  logic                   clk_i,
  input  logic [1:0]             en_i,
  input  dqvcl_pkg::dqvcl_root_t in_i,
  output dqvcl_pkg::dqvcl_out_t  out_o
);
  import dqvcl_pkg::*;

  logic signed [VoltW-1:0] d_q, q_q;
  logic        [VoltW-1:0] pd_q, pq_q;
  logic                    over_q;
  logic [VoltW+FracW-1:0]  pd_d, pq_d;
  dqvcl_out_t              out_q;

  assign pd_d = (VoltW+FracW)'(in_i.d_mag) * (VoltW+FracW)'(in_i.scale);
  assign pq_d = (VoltW+FracW)'(in_i.q_mag) * (VoltW+FracW)'(in_i.scale);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      d_q    <= in_i.d_volt;
      q_q    <= in_i.q_volt;
      over_q <= in_i.over;
      pd_q   <= pd_d[VoltW+FracW-1:FracW];
      pq_q   <= pq_d[VoltW+FracW-1:FracW];
    end
    if (en_i[1]) begin
      out_q.over_limit <= over_q;
      if (over_q) begin
        out_q.d_limited <= d_q[VoltW-1] ? -$signed(pd_q) : $signed(pd_q);
        out_q.q_limited <= q_q[VoltW-1] ? -$signed(pq_q) : $signed(pq_q);
      end else begin
        out_q.d_limited <= d_q;
        out_q.q_limited <= q_q;
      end
    end
  end

  assign out_o = out_q;

endmodule

/* src/dq_voltage_circle_limiter.sv */
// Top level of the dq voltage circle limiter.
// Usage: each input beat carries a d/q voltage command and the DC bus voltage.
// The vector is limited to a circle of radius bus * 0.57735 * modulation_limit;
// when it lies outside, both components are scaled down toward zero and
// over_limit is set, otherwise they pass unchanged.
// The input channel takes a beat when in_valid_i is high and in_stall_o low;
// the output channel hands one over when out_valid_o is high and out_stall_i low.
// The configuration channel writes modulation_limit whenever cfg_valid_i is high;
// cfg_ready_o is always high. Write it only while the pipeline is empty.
// The pipeline has five front stages, sixteen scale search stages (one bit
// of the scale each) and two scaling and output stages.
// Throughput is one beat per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its beat and the stages
// behind it keep filling empty slots; the input stalls only once every stage is
// occupied. Reset empties the pipeline and loads modulation_limit with 62259.
module dq_voltage_circle_limiter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  dqvcl_pkg::dqvcl_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output dqvcl_pkg::dqvcl_out_t out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [15:0]           cfg_data_i
);
  import dqvcl_pkg::*;

  localparam int unsigned NumStage = 5 + NumRoot + 2;

  logic [NumStage-1:0] valid_q, en;
  logic [FracW-1:0]    mod_limit_q;
  dqvcl_root_t         chain [NumRoot+1];

  always_comb begin
    en[NumStage-1] = !valid_q[NumStage-1] || !out_stall_i;
    for (int k = NumStage - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      mod_limit_q <= ModLimitRst;
    end else begin
      if (cfg_valid_i) begin
        mod_limit_q <= cfg_data_i;
      end
      for (int k = 0; k < NumStage; k++) begin
        if (en[k]) begin
          valid_q[k] <= (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  dqvcl_front u_front (
    .clk_i       (clk_i),
    .en_i        (en[4:0]),
    .in_i        (in_data_i),
    .mod_limit_i (mod_limit_q),
    .out_o       (chain[0])
  );

  for (genvar j = 0; j < NumRoot; j++) begin : g_root
    dqvcl_root_step #(
      .BitPos (NumRoot - 1 - j)
    ) u_step (
      .clk_i (clk_i),
      .en_i  (en[5+j]),
      .in_i  (chain[j]),
      .out_o (chain[j+1])
    );
  end

  dqvcl_back u_back (
    .clk_i (clk_i),
    .en_i  (en[NumStage-1:NumStage-2]),
    .in_i  (chain[NumRoot]),
    .out_o (out_data_o)
  );

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[NumStage-1];
  assign cfg_ready_o = 1'b1;

endmodule

/* src/dqvcl_checker.sv */
// Port checker of the dq voltage circle limiter and its bind statement.
module dqvcl_port_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input dqvcl_pkg::dqvcl_out_t out_data_o,
  input logic                  cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Stalled output beat was dropped.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("Stalled output beat changed.");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled without a stalled output beat.");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o && cfg_ready_o)
    else $error("Pipeline not empty after reset.");

endmodule

bind dq_voltage_circle_limiter dqvcl_port_checker u_dqvcl_port_checker (.*);

/* sim/dqvcl_checker.sv */
// Checker for the dq voltage circle limiter: predicts each result and compares it.
`timescale 1ns / 1ps
module dqvcl_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  dqvcl_pkg::dqvcl_in_t  in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  dqvcl_pkg::dqvcl_out_t out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [15:0]           cfg_data_i,
  output int                    mismatches_o,
  output int                    pending_o,
  output int                    clipped_o
);
  import dqvcl_pkg::*;

  logic [15:0] mod_limit;
  dqvcl_out_t  limited_q[$];

  function automatic dqvcl_out_t limit_vector(dqvcl_in_t x, logic [15:0] ml);
    dqvcl_out_t  r;
    logic [63:0] dm, qm, mag2, t, rq;
    logic [127:0] r2, lhs;
    logic [16:0] s, c;
    logic [63:0] pd, pq;
    dm = (x.d_voltage < 0) ? 64'(-$signed(64'(x.d_voltage))) : 64'(x.d_voltage);
    qm = (x.q_voltage < 0) ? 64'(-$signed(64'(x.q_voltage))) : 64'(x.q_voltage);
    mag2 = dm * dm + qm * qm;
    t = 64'(x.bus_voltage) * 64'(InvSqrt3);
    rq = (t * 64'(ml)) >> 16;
    r2 = 128'(rq) * 128'(rq);
    lhs = 128'(mag2) << 32;
    if (lhs <= r2) begin
      r.d_limited = x.d_voltage;
      r.q_limited = x.q_voltage;
      r.over_limit = 1'b0;
    end else begin
      s = '0;
      for (int b = 15; b >= 0; b--) begin
        c = s | (17'd1 << b);
        if (128'(c) * 128'(c) * 128'(mag2) <= r2) s = c;
      end
      pd = (dm * 64'(s)) >> 16;
      pq = (qm * 64'(s)) >> 16;
      r.d_limited = (x.d_voltage < 0) ? 16'(-pd) : 16'(pd);
      r.q_limited = (x.q_voltage < 0) ? 16'(-pq) : 16'(pq);
      r.over_limit = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dqvcl_out_t e;
    if (!rst_ni) begin
      mod_limit <= ModLimitRst;
      mismatches_o <= 0;
      clipped_o <= 0;
      limited_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) mod_limit <= cfg_data_i;
      if (in_valid_i && !in_stall_i) limited_q.push_back(limit_vector(in_data_i, mod_limit));
      if (out_valid_i && !out_stall_i) begin
        if (out_data_i.over_limit) clipped_o <= clipped_o + 1;
        if (limited_q.size() == 0) begin
          if (mismatches_o < 10) $display("Unexpected result beat %p", out_data_i);
          mismatches_o <= mismatches_o + 1;
        end else begin
          e = limited_q.pop_front();
          if (e !== out_data_i) begin
            if (mismatches_o < 10) $display("Expected %p, got %p", e, out_data_i);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = limited_q.size();
endmodule

/* sim/tb_top.sv */
// Testbench top for the dq voltage circle limiter: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb_top;
  import dqvcl_pkg::*;

  localparam int Latency = 23;
  localparam int WatchLimit = 2000;

  logic       clk, rst_n;
  logic       in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  dqvcl_in_t  in_data;
  dqvcl_out_t out_data;
  logic [15:0] cfg_data;
  int mismatches, pending, clipped, idle_cycles, sent, idle_pct;
  bit stall_rand;

  dq_voltage_circle_limiter DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  dqvcl_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .mismatches_o(mismatches), .pending_o(pending), .clipped_o(clipped)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(negedge clk) out_stall <= stall_rand && ($urandom_range(99) < 20);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_vector(logic [15:0] d, logic [15:0] q, logic [15:0] bus);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{d_voltage: d, q_voltage: q, bus_voltage: bus};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (Latency + 2) @(negedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n);
    logic [15:0] d, q, bus;
    for (int i = 0; i < n; i++) begin
      bus = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
      case ($urandom_range(3))
        0: begin d = 16'($urandom); q = 16'($urandom); end
        1: begin
          d = 16'($signed($urandom_range(2000)) - 1000);
          q = 16'($signed($urandom_range(2000)) - 1000);
        end
        2: begin d = 16'($urandom_range(300)); q = 16'(-$signed($urandom_range(300))); end
        default: begin d = 16'($urandom); q = 16'($urandom_range(3)); end
      endcase
      send_vector(d, q, bus);
      if (i == n / 2) idle_pct = 0;
      if (i == 3 * n / 4) idle_pct = 20;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    stall_rand = 1'b1;
    idle_cycles = 0;
    sent = 0;
    idle_pct = 20;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    // Directed beats: zero vector, extremes and zero bus.
    send_vector(16'h0000, 16'h0000, 16'hFFFF);
    send_vector(16'h0000, 16'h0000, 16'h0000);
    send_vector(16'h8000, 16'h8000, 16'hFFFF);
    send_vector(16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_vector(16'h8000, 16'h7FFF, 16'h0000);
    send_vector(16'h0001, 16'hFFFF, 16'h0000);
    send_vector(16'h7FFF, 16'h8000, 16'd1000);
    send_vector(16'd100, 16'd0, 16'd1);
    send_vector(16'hFFFF, 16'h0001, 16'hFFFF);
    write_limit(16'd0);
    send_vector(16'd5, 16'hFFFB, 16'd3000);
    send_vector(16'h0000, 16'h0000, 16'd3000);
    write_limit(16'd32768);
    // With the limit at one half and bus 2, the radius is exactly 37838 / 65536.
    send_vector(16'd0, 16'd0, 16'd2);
    send_vector(16'd1, 16'd0, 16'd4);
    send_vector(16'd0, 16'hFFFF, 16'd4);
    write_limit(16'hFFFF);
    send_vector(16'h8000, 16'h0000, 16'hFFFF);
    send_vector(16'h1234, 16'hEDCB, 16'h5555);
    random_phase(150);
    // Hold the sender until every outstanding result has come back.
    drain_pipeline();
    random_phase(50);
    write_limit(16'd62259);
    random_phase(130);
    write_limit(16'($urandom));
    stall_rand = 1'b0;
    random_phase(100);
    drain_pipeline();
    $display("Sent %0d beats over five limit settings; %0d results were clipped.",
             sent, clipped);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
